### rtl/core/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
// No dependencies; used by sfr_window, stream_find_replace_top and the testbench.
`default_nettype none

package sfr_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned MaxSearch  = 8;
  localparam int unsigned MaxReplace = 8;
  localparam int unsigned PatW       = MaxSearch * ByteW;
  localparam int unsigned RepW       = MaxReplace * ByteW;
  localparam int unsigned LenW       = 4;
  localparam int unsigned WinIdxW    = $clog2(MaxSearch);
  localparam int unsigned RepIdxW    = $clog2(MaxReplace);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSearchBytes,
    CfgSearchLength,
    CfgReplaceBytes,
    CfgReplaceLength
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StCheck,
    StFlush,
    StRepl,
    StEnd
  } state_e;

  typedef struct packed {
    logic append;
    logic shift;
    logic clear;
  } win_ctrl_t;

  typedef struct packed {
    logic [LenW-1:0]  fill;
    logic [ByteW-1:0] oldest;
    logic             prefix;
    logic             full_match;
  } win_stat_t;

  function automatic logic [LenW-1:0] sat_len(logic [LenW-1:0] n, logic [LenW-1:0] lim);
    sat_len = (n > lim) ? lim : n;
  endfunction

endpackage

`default_nettype wire

### rtl/core/sfr_window.sv
// Match window: byte shift line, fill count and the shared prefix comparator.
// Depends on sfr_pkg.
`default_nettype none

module sfr_window (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire sfr_pkg::win_ctrl_t           ctrl_i,
  input  wire logic [sfr_pkg::ByteW-1:0]    byte_i,
  input  wire logic [sfr_pkg::PatW-1:0]     pattern_i,
  input  wire logic [sfr_pkg::LenW-1:0]     slen_i,
  output sfr_pkg::win_stat_t                stat_o
);

  logic [sfr_pkg::ByteW-1:0] win_q [sfr_pkg::MaxSearch];
  logic [sfr_pkg::LenW-1:0]  fill_q, fill_d;
  logic [sfr_pkg::MaxSearch-1:0] lane_ok;
  logic prefix;

  always_comb begin
    fill_d = fill_q;
    if (ctrl_i.clear) begin
      fill_d = '0;
    end else if (ctrl_i.shift) begin
      fill_d = fill_q - sfr_pkg::LenW'(1);
    end else if (ctrl_i.append) begin
      fill_d = fill_q + sfr_pkg::LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      for (int i = 0; i < sfr_pkg::MaxSearch - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
    end else if (ctrl_i.append) begin
      win_q[fill_q[sfr_pkg::WinIdxW-1:0]] <= byte_i;
    end
  end

  // unused lanes beyond the fill always pass
  always_comb begin
    for (int i = 0; i < sfr_pkg::MaxSearch; i++) begin
      lane_ok[i] = (sfr_pkg::LenW'(i) >= fill_q) ||
                   (win_q[i] == pattern_i[i*sfr_pkg::ByteW +: sfr_pkg::ByteW]);
    end
  end

  assign prefix = (slen_i != '0) && (fill_q <= slen_i) && (&lane_ok);

  assign stat_o.fill       = fill_q;
  assign stat_o.oldest     = win_q[0];
  assign stat_o.prefix     = prefix;
  assign stat_o.full_match = prefix && (fill_q == slen_i);

endmodule

`default_nettype wire

### rtl/core/stream_find_replace_top.sv
// Stream find-and-replace top level: config registers, sequencer, output stage.
// Depends on sfr_pkg and sfr_window.
//
//  channel  dir  handshake                  payload
//  s_axis   in   tvalid/tready              tdata[7:0] text byte, tlast final byte
//  m_axis   out  tvalid/tready              tdata[7:0] byte, tuser valid, tlast end
//  cfg      in   cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
// Each input transfer takes the sequencer through load, shifting bytes out of the window,
// a decision, a closing state and idle, which accepts the next byte. A match adds the
// replacement bytes and the end of the count; a final byte that leaves a partial match
// adds the flushed bytes.
// Reset clears fill count and control; the window bytes need no clearing.
// Bytes leave via a pending slot and the output register; a stalled m_axis holds the
// sequencer at its next emitted byte.
`default_nettype none

module stream_find_replace_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,   // [7:0] text_byte
  input  wire logic                           s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [7:0]                          m_axis_tdata,   // [7:0] out_byte
  output logic                                m_axis_tuser,   // [0] byte_valid
  output logic                                m_axis_tlast,
  input  wire logic                           cfg_we_i,
  input  wire logic [sfr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [sfr_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [sfr_pkg::PatW-1:0] search_q;
  logic [sfr_pkg::RepW-1:0] replace_q;
  logic [sfr_pkg::LenW-1:0] slen_cfg_q, rlen_cfg_q, slen, rlen;

  sfr_pkg::state_e state_q, state_d;
  logic [sfr_pkg::LenW-1:0] rcnt_q, rcnt_d;
  logic [sfr_pkg::ByteW-1:0] byte_q;
  logic last_q;

  logic [sfr_pkg::ByteW-1:0] pend_byte_q;
  logic pend_v_q;
  logic [sfr_pkg::ByteW-1:0] out_byte_q;
  logic out_bv_q, out_eot_q, out_v_q;

  sfr_pkg::win_ctrl_t ctrl;
  sfr_pkg::win_stat_t stat;

  logic s_accept, out_free, can_emit;
  logic emit, push_pend, push_null;
  logic [sfr_pkg::ByteW-1:0] emit_byte;

  assign slen = sfr_pkg::sat_len(slen_cfg_q, sfr_pkg::LenW'(sfr_pkg::MaxSearch));
  assign rlen = sfr_pkg::sat_len(rlen_cfg_q, sfr_pkg::LenW'(sfr_pkg::MaxReplace));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_q   <= '0;
      slen_cfg_q <= '0;
      replace_q  <= '0;
      rlen_cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sfr_pkg::CfgSearchBytes:   search_q   <= cfg_data_i[sfr_pkg::PatW-1:0];
        sfr_pkg::CfgSearchLength:  slen_cfg_q <= cfg_data_i[sfr_pkg::LenW-1:0];
        sfr_pkg::CfgReplaceBytes:  replace_q  <= cfg_data_i[sfr_pkg::RepW-1:0];
        sfr_pkg::CfgReplaceLength: rlen_cfg_q <= cfg_data_i[sfr_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  sfr_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .byte_i    (byte_q),
    .pattern_i (search_q),
    .slen_i    (slen),
    .stat_o    (stat)
  );

  assign s_axis_tready = (state_q == sfr_pkg::StIdle);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_v_q || m_axis_tready;
  // a new byte parks in the pending slot; the previous one moves to the output
  assign can_emit      = !pend_v_q || out_free;

  always_comb begin
    state_d   = state_q;
    rcnt_d    = rcnt_q;
    ctrl      = '0;
    emit      = 1'b0;
    emit_byte = stat.oldest;
    push_pend = 1'b0;
    push_null = 1'b0;
    case (state_q)
      sfr_pkg::StIdle: begin
        if (s_accept) begin
          state_d = sfr_pkg::StLoad;
        end
      end
      sfr_pkg::StLoad: begin
        if (stat.fill == sfr_pkg::LenW'(sfr_pkg::MaxSearch)) begin
          if (can_emit) begin
            emit       = 1'b1;
            ctrl.shift = 1'b1;
          end
        end else begin
          ctrl.append = 1'b1;
          state_d     = sfr_pkg::StCheck;
        end
      end
      sfr_pkg::StCheck: begin
        if (stat.fill == '0) begin
          state_d = sfr_pkg::StEnd;
        end else if (stat.prefix) begin
          if (stat.full_match) begin
            ctrl.clear = 1'b1;
            rcnt_d     = '0;
            state_d    = sfr_pkg::StRepl;
          end else begin
            state_d = last_q ? sfr_pkg::StFlush : sfr_pkg::StEnd;
          end
        end else if (can_emit) begin
          emit       = 1'b1;
          ctrl.shift = 1'b1;
        end
      end
      sfr_pkg::StFlush: begin
        if (stat.fill == '0) begin
          state_d = sfr_pkg::StEnd;
        end else if (can_emit) begin
          emit       = 1'b1;
          ctrl.shift = 1'b1;
        end
      end
      sfr_pkg::StRepl: begin
        emit_byte = replace_q[rcnt_q[sfr_pkg::RepIdxW-1:0]*sfr_pkg::ByteW +: sfr_pkg::ByteW];
        if (rcnt_q == rlen) begin
          state_d = sfr_pkg::StEnd;
        end else if (can_emit) begin
          emit   = 1'b1;
          rcnt_d = rcnt_q + sfr_pkg::LenW'(1);
        end
      end
      sfr_pkg::StEnd: begin
        if (pend_v_q) begin
          if (out_free) begin
            push_pend = 1'b1;
            state_d   = sfr_pkg::StIdle;
          end
        end else if (last_q) begin
          if (out_free) begin
            push_null = 1'b1;
            state_d   = sfr_pkg::StIdle;
          end
        end else begin
          state_d = sfr_pkg::StIdle;
        end
      end
      default: state_d = sfr_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sfr_pkg::StIdle;
      rcnt_q   <= '0;
      last_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rcnt_q  <= rcnt_d;
      if (s_accept) begin
        last_q <= s_axis_tlast;
      end
      if (emit) begin
        pend_v_q <= 1'b1;
      end else if (push_pend) begin
        pend_v_q <= 1'b0;
      end
      if ((emit && pend_v_q) || push_pend || push_null) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      byte_q <= s_axis_tdata;
    end
    if (emit) begin
      pend_byte_q <= emit_byte;
    end
    if ((emit && pend_v_q) || push_pend) begin
      out_byte_q <= pend_byte_q;
      out_bv_q   <= 1'b1;
      out_eot_q  <= push_pend && last_q;
    end else if (push_null) begin
      out_byte_q <= '0;
      out_bv_q   <= 1'b0;
      out_eot_q  <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_bv_q;
  assign m_axis_tlast  = out_eot_q;

endmodule

`default_nettype wire

### rtl/core/sfr_checker.sv
// Port-level checks for stream_find_replace_top, attached by bind.
// Depends on nothing else; sees only the top level's ports.
`default_nettype none

module sfr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_tvalid_i,
  input wire logic       s_tready_i,
  input wire logic       m_tvalid_i,
  input wire logic       m_tready_i,
  input wire logic [7:0] m_tdata_i,
  input wire logic       m_tuser_i,
  input wire logic       m_tlast_i
);

  // output transfer held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) &&
    $stable(m_tuser_i) && $stable(m_tlast_i))
    else $error("m_axis payload changed under stall");

  // an empty result only closes a text
  a_null_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tuser_i |-> m_tlast_i && (m_tdata_i == 8'd0))
    else $error("empty result without end of text");

  // one byte in at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("input accepted back to back");

  // if input ready rises while a closing result is stalled, that result stays valid
  a_end_before_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tlast_i && !m_tready_i && !s_tready_i |=> !s_tready_i || m_tvalid_i)
    else $error("ready raised while closing result pending");

endmodule

bind stream_find_replace_top sfr_checker u_sfr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata),
  .m_tuser_i  (m_axis_tuser),
  .m_tlast_i  (m_axis_tlast)
);

`default_nettype wire

### tb/sv/sfr_tb_pkg.sv
// Expected-output tracker for the stream find-and-replace testbench.
// Depends on sfr_pkg for the register codes and the window size.
package sfr_tb_pkg;

  import sfr_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eot;
  } text_out_t;

  class rewrite_tracker;
    logic [63:0] pattern;
    logic [3:0]  pattern_len;
    logic [63:0] replacement;
    logic [3:0]  replacement_len;
    logic [7:0]  window [MaxSearch];
    int unsigned window_fill;
    text_out_t   step_out [$];
    text_out_t   awaited [$];
    int unsigned mismatches;
    int unsigned seen;

    function new();
      pattern         = '0;
      pattern_len     = '0;
      replacement     = '0;
      replacement_len = '0;
      window_fill     = 0;
      mismatches      = 0;
      seen            = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [63:0] value);
      case (idx)
        CfgSearchBytes:   pattern = value;
        CfgSearchLength:  pattern_len = value[3:0];
        CfgReplaceBytes:  replacement = value;
        CfgReplaceLength: replacement_len = value[3:0];
        default: ;
      endcase
    endfunction

    function int unsigned awaited_count();
      return awaited.size();
    endfunction

    function void emit(logic [7:0] b, logic v);
      text_out_t r;
      r.data  = b;
      r.valid = v;
      r.eot   = 1'b0;
      if (step_out.size() < 16) step_out.push_back(r);
    endfunction

    function void shift_oldest();
      if (window_fill == 0) return;
      emit(window[0], 1'b1);
      for (int i = 1; i < window_fill; i++) window[i-1] = window[i];
      window_fill--;
    endfunction

    function bit is_prefix(int unsigned len);
      if (len == 0 || window_fill > len) return 1'b0;
      for (int i = 0; i < window_fill; i++)
        if (window[i] != pattern[8*i +: 8]) return 1'b0;
      return 1'b1;
    endfunction

    // Accepted input transfer: work out every result it causes.
    function void take_text_byte(logic [7:0] b, logic last);
      int unsigned slen;
      int unsigned rlen;
      slen = (pattern_len > MaxSearch) ? MaxSearch : pattern_len;
      rlen = (replacement_len > MaxReplace) ? MaxReplace : replacement_len;
      step_out.delete();
      if (window_fill > MaxSearch) window_fill = MaxSearch;
      while (window_fill >= MaxSearch) shift_oldest();
      window[window_fill] = b;
      window_fill++;
      while (window_fill > 0) begin
        if (is_prefix(slen)) begin
          if (window_fill == slen) begin
            for (int i = 0; i < rlen; i++) emit(replacement[8*i +: 8], 1'b1);
            window_fill = 0;
          end
          break;
        end
        shift_oldest();
      end
      if (last) begin
        while (window_fill > 0) shift_oldest();
        if (step_out.size() == 0) emit(8'h00, 1'b0);
        step_out[step_out.size()-1].eot = 1'b1;
      end
      foreach (step_out[i]) awaited.push_back(step_out[i]);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("MISMATCH %s", what);
    endtask

    task check_out_byte(logic [7:0] data, logic valid, logic eot);
      text_out_t got;
      text_out_t want;
      got.data  = data;
      got.valid = valid;
      got.eot   = eot;
      seen++;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing awaited: byte %02h valid %0b end %0b",
                                  seen, data, valid, eot));
        return;
      end
      want = awaited.pop_front();
      if (got !== want)
        report_mismatch($sformatf("result %0d: byte %02h valid %0b end %0b, want %02h %0b %0b",
                                  seen, data, valid, eot, want.data, want.valid, want.eot));
    endtask
  endclass

endpackage

### tb/sv/testbench.sv
// Top-level testbench for stream_find_replace_top: drives text transfers and
// register writes, checks every output transfer against rewrite_tracker.
// Depends on sfr_pkg, sfr_tb_pkg and the block's RTL.
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;
  import sfr_tb_pkg::*;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  rewrite_tracker rewrite = new();

  int gap_odds   = 4;
  int stall_odds = 4;
  int stall_left = 0;

  stream_find_replace_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // receiver stalls in bursts of random length
  always @(posedge clk_i) begin
    if (!rst_ni || stall_odds == 0) begin
      stall_left = 0;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(1, stall_odds) == 1) begin
      stall_left = $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      rewrite.check_out_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  task automatic send_text(input logic [7:0] b, input logic last);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    rewrite.take_text_byte(b, last);
  endtask

  // hold off the sender until every awaited result is out, then let the
  // block finish any byte that gave no result
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (rewrite.awaited_count() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [63:0] srch, input logic [63:0] srch_len,
                                input logic [63:0] rep, input logic [63:0] rep_len);
    cfg_reg_e    order [4];
    logic [63:0] vals [4];
    order = '{CfgSearchBytes, CfgSearchLength, CfgReplaceBytes, CfgReplaceLength};
    vals  = '{srch, srch_len, rep, rep_len};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= order[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      rewrite.write_reg(order[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_round(input int n_items);
    logic [63:0] pat;
    logic [63:0] rep;
    logic [63:0] slen_word;
    logic [63:0] rlen_word;
    logic [7:0]  a;
    logic [7:0]  z;
    logic [7:0]  b;
    bit          two_letter;
    int          plen;
    int          sent;
    int          pick;
    two_letter = ($urandom_range(0, 2) == 0);
    a = 8'($urandom_range(0, 255));
    z = 8'($urandom_range(0, 255));
    for (int i = 0; i < 8; i++)
      pat[8*i +: 8] = two_letter ? ($urandom_range(0, 1) ? a : z) : 8'($urandom_range(0, 255));
    rep       = {$urandom, $urandom};
    slen_word = {$urandom, $urandom};
    rlen_word = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       slen_word[3:0] = 4'd0;
      1:       slen_word[3:0] = 4'd1;
      2:       slen_word[3:0] = 4'd8;
      3:       slen_word[3:0] = 4'($urandom_range(9, 15));
      default: slen_word[3:0] = 4'($urandom_range(1, 8));
    endcase
    rlen_word[3:0] = 4'($urandom_range(0, 15));
    plen = (slen_word[3:0] == 0) ? 4 : (slen_word[3:0] > 8 ? 8 : int'(slen_word[3:0]));
    wait_idle();
    write_settings(pat, slen_word, rep, rlen_word);
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        // whole pattern, now and then broken on its last byte
        for (int k = 0; k < plen && sent < n_items; k++) begin
          b = pat[8*k +: 8];
          if (k == plen - 1 && $urandom_range(0, 4) == 0) b = 8'($urandom_range(0, 255));
          send_text(b, $urandom_range(0, 19) == 0);
          sent++;
        end
      end else if (pick < 8) begin
        send_text(pat[8*$urandom_range(0, plen - 1) +: 8], $urandom_range(0, 19) == 0);
        sent++;
      end else begin
        send_text(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: search length zero, bytes pass through
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b1);

    // "ab" -> "XYZ": repeated prefix, back-to-back matches, partial match flushed
    wait_idle();
    write_settings(64'h6261, 64'd2, 64'h5A5958, 64'd3);
    send_text(8'h61, 1'b0);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b0);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b0);
    send_text(8'h62, 1'b0);
    send_text(8'h61, 1'b1);

    // deletion: final step gives no byte, so an empty end-of-text transfer
    wait_idle();
    write_settings(64'h6261, 64'd2, 64'h5A5958, 64'd0);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b1);

    // oversized lengths saturate; full eight-byte window matches
    wait_idle();
    write_settings('1, 64'd15, 64'h0123_4567_89AB_CDEF, 64'd15);
    for (int i = 0; i < 8; i++) send_text(8'hFF, i == 7);

    // pattern changed while the window holds a partial match
    wait_idle();
    write_settings(64'h636261, 64'd3, 64'h5A5958, 64'd3);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b0);
    wait_idle();
    write_settings(64'h7861, 64'd2, 64'h5A5958, 64'd3);
    send_text(8'h63, 1'b1);

    for (int r = 0; r < 9; r++) begin
      if (r == 8) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = (r % 3 == 2) ? 0 : $urandom_range(2, 8);
        stall_odds = (r % 4 == 1) ? 0 : $urandom_range(2, 8);
      end
      random_round(26);
    end

    wait_idle();
    if (rewrite.mismatches == 0) begin
      $display("stream_find_replace_top test passed");
    end else begin
      $display("stream_find_replace_top test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("stream_find_replace_top test failed");
    $finish;
  end

endmodule
